>>> rtl/bld_pkg.sv
// Shared constants, opcodes and control types for the bitmap line draw engine.
package bld_pkg;

  localparam int COLUMNS = 32;
  localparam int ROWS    = 8;
  localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int OP_W    = 3;
  localparam int CRD_W   = 7;
  // error term: |dx|,|dy| <= 127, err stays within about +/-254
  localparam int ERR_W   = 10;

  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_MOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_SET   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLR   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;
  localparam logic [OP_W-1:0] OP_LINE  = 3'd5;

  typedef struct packed {
    logic load;   // capture the request
    logic exec;   // run a clear, move, set, clear-pixel or read op, or set up a line
    logic step;   // plot one line pixel, advance the cursor
    logic push;   // load the output register
  } bld_cmd_t;

  typedef struct packed {
    logic is_line;
    logic at_target;
  } bld_sts_t;

endpackage

>>> rtl/bld_dp.sv
// Datapath: bitmap, cursor, Bresenham stepper and output register.
module bld_dp import bld_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bld_cmd_t       cmd_i,
  input  logic [15:0]    s_tdata_i,   // [6:0] target_x, [13:7] target_y
  input  logic [OP_W-1:0] s_tuser_i,  // [2:0] opcode
  output bld_sts_t       sts_o,
  output logic [15:0]    m_tdata_o    // [0] pixel, [7:1] cursor_x, [14:8] cursor_y
);

  logic [OP_W-1:0]         op_q;
  logic signed [CRD_W-1:0] tgt_x_q, tgt_y_q;
  logic signed [CRD_W-1:0] cur_x_q, cur_y_q;
  logic [ROWS-1:0]         bmp_q [COLUMNS];
  logic signed [ERR_W-1:0] dx_q, dy_q, err_q;
  logic signed [ERR_W-1:0] dx_d, dy_d, err_d;
  logic                    sx_q, sy_q;
  logic signed [CRD_W:0]   ax, ay;
  logic [CRD_W:0]          adx, ady;
  logic signed [ERR_W:0]   e2, dx_ext, dy_ext;
  logic                    step_x, step_y;
  logic                    in_bmp, pix_rd, at_target;
  logic [COL_W-1:0]        col_idx;
  logic [ROW_W-1:0]        bit_idx;
  logic                    pix_out_q;
  logic [CRD_W-1:0]        out_x_q, out_y_q;

  // bounds and bit position at the cursor (row 0 is the MSB of a column)
  assign in_bmp = !cur_x_q[CRD_W-1]
                  && ({1'b0, cur_x_q[CRD_W-2:0]} < CRD_W'(COLUMNS))
                  && !cur_y_q[CRD_W-1]
                  && (cur_y_q[CRD_W-2:ROW_W] == '0);
  assign col_idx = cur_x_q[COL_W-1:0];
  assign bit_idx = ~cur_y_q[ROW_W-1:0];
  assign pix_rd  = in_bmp && bmp_q[col_idx][bit_idx];

  assign at_target = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

  // line setup
  always_comb begin
    ax   = {tgt_x_q[CRD_W-1], tgt_x_q} - {cur_x_q[CRD_W-1], cur_x_q};
    ay   = {tgt_y_q[CRD_W-1], tgt_y_q} - {cur_y_q[CRD_W-1], cur_y_q};
    adx  = ax[CRD_W] ? 8'(-ax) : 8'(ax);
    ady  = ay[CRD_W] ? 8'(-ay) : 8'(ay);
    dx_d = $signed({{(ERR_W-CRD_W-1){1'b0}}, adx});
    dy_d = -$signed({{(ERR_W-CRD_W-1){1'b0}}, ady});
  end

  // one Bresenham step
  always_comb begin
    e2     = $signed({err_q, 1'b0});
    dx_ext = $signed({dx_q[ERR_W-1], dx_q});
    dy_ext = $signed({dy_q[ERR_W-1], dy_q});
    step_x = (e2 >= dy_ext);
    step_y = (e2 <= dx_ext);
    err_d  = err_q + (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= s_tuser_i;
      tgt_x_q <= s_tdata_i[CRD_W-1:0];
      tgt_y_q <= s_tdata_i[2*CRD_W-1:CRD_W];
    end
    if (cmd_i.exec) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      err_q <= dx_d + dy_d;
      sx_q  <= cur_x_q < tgt_x_q;
      sy_q  <= cur_y_q < tgt_y_q;
    end else if (cmd_i.step) begin
      err_q <= err_d;
    end
    if (cmd_i.push) begin
      pix_out_q <= (op_q == OP_READ) && pix_rd;
      out_x_q   <= cur_x_q;
      out_y_q   <= cur_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      bmp_q   <= '{default: '0};
    end else begin
      if (cmd_i.exec) begin
        case (op_q)
          OP_CLEAR: bmp_q <= '{default: '0};
          OP_MOVE: begin
            cur_x_q <= tgt_x_q;
            cur_y_q <= tgt_y_q;
          end
          OP_SET: if (in_bmp) bmp_q[col_idx][bit_idx] <= 1'b1;
          OP_CLR: if (in_bmp) bmp_q[col_idx][bit_idx] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd_i.step) begin
        if (in_bmp) bmp_q[col_idx][bit_idx] <= 1'b1;
        if (!at_target) begin
          if (step_x) cur_x_q <= sx_q ? cur_x_q + 7'sd1 : cur_x_q - 7'sd1;
          if (step_y) cur_y_q <= sy_q ? cur_y_q + 7'sd1 : cur_y_q - 7'sd1;
        end
      end
    end
  end

  assign sts_o.is_line   = (op_q == OP_LINE);
  assign sts_o.at_target = at_target;
  assign m_tdata_o       = {1'b0, out_y_q, out_x_q, pix_out_q};

endmodule

>>> rtl/bld_ctl.sv
// Controller: request sequencing, line loop control and output valid.
module bld_ctl import bld_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  output logic     m_tvalid_o,
  input  logic     m_tready_i,
  input  bld_sts_t sts_i,
  output bld_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LINE = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       out_free;

  assign out_free   = !m_valid_q || m_tready_i;
  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_line ? S_LINE : S_PUSH;
      end
      S_LINE: begin
        cmd_o.step = 1'b1;
        if (sts_i.at_target) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign m_valid_d = cmd_o.push ? 1'b1 : (m_tready_i ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_tvalid_o = m_valid_q;

`ifndef ASSERT_OFF
  a_line_only_for_line_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINE) |-> sts_i.is_line)
    else $error("line loop running for a non-line request");

  a_push_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (!m_valid_q || m_tready_i))
    else $error("output register overwritten while full");

  a_accept_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == S_EXEC))
    else $error("accepted request not executed");

  a_line_ends_in_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINE && sts_i.at_target) |=> (state_q == S_PUSH))
    else $error("line did not finish at its target");
`endif

endmodule

>>> rtl/bitmap_line_draw_engine.sv
// Top level of the bitmap line draw engine: controller plus datapath.
// Holds a 32x8 monochrome bitmap and a signed cursor. Each request yields
// one result. A clear, move, set, clear-pixel or read goes through capture,
// execute and output load; a line goes through capture, line setup, the
// Bresenham stepper that plots one pixel per cycle up to and including the
// target, and output load. The next request is accepted once the previous
// one has reached the output register, even if that result has not yet
// been taken.
module bitmap_line_draw_engine import bld_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,  // [6:0] target_x, [13:7] target_y, [15:14] zero
  input  logic [OP_W-1:0] s_axis_tuser,  // [2:0] opcode
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata   // [0] pixel, [7:1] cursor_x, [14:8] cursor_y
);

  bld_cmd_t cmd;
  bld_sts_t sts;

  bld_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bld_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .sts_o     (sts),
    .m_tdata_o (m_axis_tdata)
  );

endmodule
